[rtl/core/rfre_pkg.sv]
// rfre_pkg: shared codes and widths for the raft follower rpc engine
// no dependencies; imported by rfre_term_store and raft_follower_rpc_engine_core
`default_nettype none

package rfre_pkg;

   localparam int TERM_W = 32;   // term width
   localparam int LIDX_W = 16;   // log index width on the wire
   localparam int CNT_W  = 11;   // entry count width
   localparam int WIDX_W = 17;   // write index, holds previous index plus one
   localparam int CMD_W  = 2;
   localparam int RUN_W  = 2;

   typedef logic [CMD_W-1:0] cmd_type;
   typedef logic [RUN_W-1:0] run_type;

   localparam cmd_type CMD_VOTE   = 2'd0;
   localparam cmd_type CMD_HEADER = 2'd1;
   localparam cmd_type CMD_ENTRY  = 2'd2;

   localparam run_type RUN_IDLE      = 2'd0;
   localparam run_type RUN_APPENDING = 2'd1;
   localparam run_type RUN_REJECTED  = 2'd2;

   localparam logic KIND_VOTE   = 1'b0;
   localparam logic KIND_APPEND = 1'b1;

endpackage

`default_nettype wire

[rtl/core/rfre_term_store.sv]
// rfre_term_store: single-port-write, registered-read memory of log entry terms
// depends on rfre_pkg for the term width
`default_nettype none

module rfre_term_store
   import rfre_pkg::*;
#(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  wire logic              clock,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [TERM_W-1:0] rd_data,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [TERM_W-1:0] wr_data
);

   logic [TERM_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

[rtl/core/raft_follower_rpc_engine_core.sv]
// raft_follower_rpc_engine_core: follower side of raft vote and append handling
// response: rsp_tvalid is registered, set when an accepted request executes and emits; a new
// request is taken only after the last has executed, as the term store read precedes
// the update and write-back; a held response stalls the update until rsp frees up
// reset: synchronous, active high; clears term, vote, log length, commit and run state
// depends on rfre_pkg and rfre_term_store
`default_nettype none

module raft_follower_rpc_engine_core
   import rfre_pkg::*;
#(
   parameter int LOG_DEPTH    = 1024,
   parameter int NODE_ID_BITS = 8,
   localparam int REQ_DATA_W  = ((3 * TERM_W + 3 * LIDX_W - LIDX_W + CNT_W
                                  + NODE_ID_BITS + 7) / 8) * 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // msg_term, node_id, log_index, log_term, lead_commit, entry_count, entry_term
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // command
   input  wire logic [CMD_W-1:0]      req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // reply_term, granted, match_idx
   output logic [55:0]                rsp_tdata,
   // reply_kind
   output logic                       rsp_tuser
);

   localparam int IDX_W = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
   localparam int NID_B = TERM_W;
   localparam int LI_B  = NID_B + NODE_ID_BITS;
   localparam int LT_B  = LI_B + LIDX_W;
   localparam int LC_B  = LT_B + TERM_W;
   localparam int CNT_B = LC_B + LIDX_W;
   localparam int ET_B  = CNT_B + CNT_W;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   // request fields
   logic [TERM_W-1:0]       f_mt, f_lt, f_et;
   logic [NODE_ID_BITS-1:0] f_nid;
   logic [LIDX_W-1:0]       f_li, f_lc;
   logic [CNT_W-1:0]        f_cnt;

   assign f_mt  = req_tdata[0 +: TERM_W];
   assign f_nid = req_tdata[NID_B +: NODE_ID_BITS];
   assign f_li  = req_tdata[LI_B +: LIDX_W];
   assign f_lt  = req_tdata[LT_B +: TERM_W];
   assign f_lc  = req_tdata[LC_B +: LIDX_W];
   assign f_cnt = req_tdata[CNT_B +: CNT_W];
   assign f_et  = req_tdata[ET_B +: TERM_W];

   // control and persistent state
   logic                    state_ff, state_in;
   logic [TERM_W-1:0]       term_ff, term_in;
   logic                    vote_held_ff, vote_held_in;
   logic [NODE_ID_BITS-1:0] vote_target_ff, vote_target_in;
   logic [NODE_ID_BITS:0]   leader_seen_ff, leader_seen_in;
   logic [IDX_W-1:0]        last_ff, last_in;
   logic [LIDX_W-1:0]       commit_ff, commit_in;
   logic [CNT_W-1:0]        left_ff, left_in;
   logic [WIDX_W-1:0]       widx_ff, widx_in;
   run_type                 run_ff, run_in;
   logic [LIDX_W-1:0]       rcommit_ff, rcommit_in;

   // captured request
   cmd_type                 cmd_ff;
   logic [TERM_W-1:0]       mt_ff, lt_ff, et_ff;
   logic [NODE_ID_BITS-1:0] nid_ff;
   logic [LIDX_W-1:0]       li_ff, lc_ff;
   logic [CNT_W-1:0]        cnt_ff;
   logic                    zero_ff, zero_in;

   // response register
   logic                    rsp_valid_ff;
   logic [55:0]             rsp_data_ff;
   logic                    rsp_kind_ff;

   logic                    accept, rsp_free, exec_fire;
   logic [IDX_W-1:0]        rd_addr;
   logic [TERM_W-1:0]       rd_data, stored;
   logic                    wr_en;
   logic [TERM_W-1:0]       wr_data;

   logic                    emit, finish, grant, kind, vh_adj, fresh, ok;
   logic [LIDX_W-1:0]       match;
   logic [LIDX_W-1:0]       last_ext;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign exec_fire  = (state_ff == ST_EXEC) && rsp_free;

   // read address and zero-term flag, taken at acceptance
   always_comb begin
      rd_addr = last_ff;
      zero_in = 1'b0;
      case (req_tuser)
         CMD_VOTE: begin
            rd_addr = last_ff;
            zero_in = (last_ff == '0);
         end
         CMD_HEADER: begin
            rd_addr = f_li[IDX_W-1:0];
            zero_in = (f_li == '0) || (f_li > LIDX_W'(last_ff));
         end
         CMD_ENTRY: begin
            rd_addr = widx_ff[IDX_W-1:0];
         end
         default: begin
            rd_addr = last_ff;
         end
      endcase
   end

   rfre_term_store #(
      .DEPTH  (LOG_DEPTH),
      .ADDR_W (IDX_W)
   ) u_store (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (widx_ff[IDX_W-1:0]),
      .wr_data (wr_data)
   );

   assign stored  = zero_ff ? '0 : rd_data;
   assign wr_data = et_ff;

   // request execution: read data is in hand, work out the new state
   always_comb begin
      state_in       = state_ff;
      term_in        = term_ff;
      vote_held_in   = vote_held_ff;
      vote_target_in = vote_target_ff;
      leader_seen_in = leader_seen_ff;
      last_in        = last_ff;
      commit_in      = commit_ff;
      left_in        = left_ff;
      widx_in        = widx_ff;
      run_in         = run_ff;
      rcommit_in     = rcommit_ff;
      emit           = 1'b0;
      finish         = 1'b0;
      grant          = 1'b0;
      kind           = KIND_VOTE;
      match          = '0;
      wr_en          = 1'b0;
      vh_adj         = vote_held_ff;
      fresh          = 1'b0;
      ok             = 1'b0;
      last_ext       = '0;

      if (accept) begin
         state_in = ST_EXEC;
      end

      if (exec_fire) begin
         state_in = ST_IDLE;
         case (cmd_ff)
            CMD_VOTE: begin
               run_in  = RUN_IDLE;
               left_in = '0;
               emit    = 1'b1;
               kind    = KIND_VOTE;
               if (mt_ff >= term_ff) begin
                  if (mt_ff > term_ff) begin
                     term_in = mt_ff;
                     vh_adj  = 1'b0;
                  end
                  vote_held_in = vh_adj;
                  fresh = (lt_ff > stored) ||
                          ((lt_ff == stored) && (li_ff >= LIDX_W'(last_ff)));
                  if (fresh && (!vh_adj || (vote_target_ff == nid_ff))) begin
                     grant          = 1'b1;
                     vote_held_in   = 1'b1;
                     vote_target_in = nid_ff;
                  end
               end
            end
            CMD_HEADER: begin
               run_in = RUN_REJECTED;
               if (mt_ff >= term_ff) begin
                  if (mt_ff > term_ff) begin
                     term_in      = mt_ff;
                     vote_held_in = 1'b0;
                  end
                  leader_seen_in = {1'b0, nid_ff};
                  if ((li_ff <= LIDX_W'(last_ff)) && (stored == lt_ff)) begin
                     run_in = RUN_APPENDING;
                  end
               end
               widx_in    = WIDX_W'(li_ff) + WIDX_W'(1);
               rcommit_in = lc_ff;
               left_in    = cnt_ff;
               finish     = (cnt_ff == '0);
            end
            CMD_ENTRY: begin
               if ((run_ff != RUN_IDLE) && (left_ff != '0)) begin
                  if (run_ff == RUN_APPENDING) begin
                     if (widx_ff <= WIDX_W'(last_ff)) begin
                        // conflicting term: truncate then append, so the log ends here
                        if (stored != et_ff) begin
                           wr_en   = 1'b1;
                           last_in = widx_ff[IDX_W-1:0];
                        end
                        widx_in = widx_ff + WIDX_W'(1);
                     end else if (widx_ff >= WIDX_W'(LOG_DEPTH)) begin
                        run_in = RUN_REJECTED;
                     end else begin
                        wr_en   = 1'b1;
                        last_in = widx_ff[IDX_W-1:0];
                        widx_in = widx_ff + WIDX_W'(1);
                     end
                  end
                  left_in = left_ff - CNT_W'(1);
                  finish  = (left_ff == CNT_W'(1));
               end
            end
            default: begin
               emit = 1'b0;
            end
         endcase

         if (finish) begin
            emit     = 1'b1;
            kind     = KIND_APPEND;
            ok       = (run_in == RUN_APPENDING);
            run_in   = RUN_IDLE;
            left_in  = '0;
            last_ext = LIDX_W'(last_in);
            if (ok) begin
               grant = 1'b1;
               match = last_ext;
               if (rcommit_in > commit_ff) begin
                  commit_in = (rcommit_in < last_ext) ? rcommit_in : last_ext;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         term_ff        <= '0;
         vote_held_ff   <= 1'b0;
         vote_target_ff <= '0;
         leader_seen_ff <= '1;
         last_ff        <= '0;
         commit_ff      <= '0;
         left_ff        <= '0;
         widx_ff        <= '0;
         run_ff         <= RUN_IDLE;
         rcommit_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         term_ff        <= term_in;
         vote_held_ff   <= vote_held_in;
         vote_target_ff <= vote_target_in;
         leader_seen_ff <= leader_seen_in;
         last_ff        <= last_in;
         commit_ff      <= commit_in;
         left_ff        <= left_in;
         widx_ff        <= widx_in;
         run_ff         <= run_in;
         rcommit_ff     <= rcommit_in;
         if (exec_fire && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= req_tuser;
         mt_ff   <= f_mt;
         nid_ff  <= f_nid;
         li_ff   <= f_li;
         lt_ff   <= f_lt;
         lc_ff   <= f_lc;
         cnt_ff  <= f_cnt;
         et_ff   <= f_et;
         zero_ff <= zero_in;
      end
      if (exec_fire && emit) begin
         rsp_data_ff <= {7'b0, match, grant, term_in};
         rsp_kind_ff <= kind;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;

endmodule

`default_nettype wire
